// ----- hdl/eyx_pkg.sv -----
// ---------------------------------------------------------------------------
// eyx_pkg
// Shared types, fixed-point constants and helpers for the Y-X-Z Euler
// rotation, scale and translation matrix block.
// ---------------------------------------------------------------------------
package eyx_pkg;

    // default parameter values
    localparam int ANGLE_FRAC_DEF   = 12;
    localparam int VALUE_FRAC_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // field and internal widths
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 32;
    localparam int TRIG_W  = 32;
    localparam int ROT_W   = 33;
    localparam int CNT_W   = 3;

    // reciprocal lane depth: magnitude, overflow check, one stage per
    // quotient bit, sign and saturation
    localparam int RCP_LAT = VALUE_W + 3;

    // column sequence codes
    localparam logic [CNT_W-1:0] CNT_TRANSL       = 3'd3;
    localparam logic [CNT_W-1:0] CNT_FIRST_NORMAL = 3'd4;
    localparam logic [CNT_W-1:0] CNT_LAST         = 3'd6;

    // matrix kind codes
    localparam logic KIND_MODEL  = 1'b0;
    localparam logic KIND_NORMAL = 1'b1;

    // Q30 constants
    localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [35:0] Q30_HALF    = 36'sd536870912;
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

    // one item handed from the front pipeline to the column emitter
    typedef struct packed {
        logic [2:0][2:0][ROT_W-1:0] rot;     // [row][element]
        logic [2:0][VALUE_W-1:0]    scale;
        logic [2:0][VALUE_W-1:0]    inv;
        logic [2:0][VALUE_W-1:0]    offset;
        logic                       zero;
    } item_t;

    // truncated Q30 arctangent of 2^-idx
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // saturate to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/eyx_sincos.sv -----
// ---------------------------------------------------------------------------
// eyx_sincos
// One sine/cosine lane: modulo 2*pi reduction, fold into +-pi/2 and a
// pipelined rotation-mode CORDIC, one step per stage.
// ---------------------------------------------------------------------------
module eyx_sincos
    import eyx_pkg::*;
#(
    parameter int ANGLE_FRAC   = ANGLE_FRAC_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]  sin_val,
    output logic signed [TRIG_W-1:0]  cos_val
);

    localparam int SH = 30 - ANGLE_FRAC;
    localparam logic [63:0] TWO_PI_U = 64'd6746518852;
    localparam logic [63:0] RED_MUL  = (64'd1 << (32 + SH)) / TWO_PI_U;
    localparam int XY_W = 34;

    // reduction, step 1: magnitude and estimated turn count
    logic [16:0]        mag_c;
    logic [63:0]        prod_c;
    logic [16:0]        r1_mag_reg;
    logic               r1_neg_reg;
    logic [5:0]         r1_q_reg;

    always_comb
    begin
        mag_c  = angle[15] ? 17'(-$signed({angle[15], angle})) : 17'(angle);
        prod_c = 64'(mag_c) * RED_MUL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_mag_reg <= mag_c;
            r1_neg_reg <= angle[15];
            r1_q_reg   <= prod_c[37:32];
        end
    end

    // reduction, step 2: remainder with one correction, sign restored
    logic [39:0]        rem_c;
    logic signed [35:0] rem_s;
    logic signed [35:0] r2_ang_reg;

    always_comb
    begin
        rem_c = (40'(r1_mag_reg) << SH) - 40'(r1_q_reg) * TWO_PI_U[39:0];
        if (rem_c >= TWO_PI_U[39:0])
            rem_c = rem_c - TWO_PI_U[39:0];
        rem_s = $signed({1'b0, rem_c[34:0]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r2_ang_reg <= r1_neg_reg ? -rem_s : rem_s;
    end

    // wrap into +-pi, fold into +-pi/2
    logic signed [35:0] fold_c;
    logic               flip_c;

    always_comb
    begin
        fold_c = r2_ang_reg;
        flip_c = 1'b0;
        if (fold_c > Q30_PI)
            fold_c = fold_c - Q30_TWO_PI;
        else if (fold_c < -Q30_PI)
            fold_c = fold_c + Q30_TWO_PI;
        if (fold_c > Q30_HALF_PI)
        begin
            fold_c = Q30_PI - fold_c;
            flip_c = 1'b1;
        end
        else if (fold_c < -Q30_HALF_PI)
        begin
            fold_c = -Q30_PI - fold_c;
            flip_c = 1'b1;
        end
    end

    // cordic stages
    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                   flip_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= XY_W'(CORDIC_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= XY_W'(fold_c);
            flip_reg[0] <= flip_c;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic [31:0] ATAN_I = atan_q30(i);
        logic signed [XY_W-1:0] atan_s;
        assign atan_s = $signed({2'b00, ATAN_I});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_s;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_s;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // cosine sign fix and clamp to +-1.0
    logic signed [XY_W-1:0] xf_c;
    logic signed [XY_W-1:0] yf_c;
    logic signed [XY_W-1:0] one_c;

    always_comb
    begin
        one_c = XY_W'(Q30_ONE);
        xf_c  = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        yf_c  = y_reg[CORDIC_STEPS];
        if (xf_c > one_c)
            xf_c = one_c;
        if (xf_c < -one_c)
            xf_c = -one_c;
        if (yf_c > one_c)
            yf_c = one_c;
        if (yf_c < -one_c)
            yf_c = -one_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_val <= TRIG_W'(xf_c);
            sin_val <= TRIG_W'(yf_c);
        end
    end

endmodule

// ----- hdl/eyx_recip.sv -----
// ---------------------------------------------------------------------------
// eyx_recip
// One reciprocal lane: rounded 2^(2*VALUE_FRAC) / |s| by a pipelined
// restoring divider, one quotient bit per stage, then sign and saturation.
// ---------------------------------------------------------------------------
module eyx_recip
    import eyx_pkg::*;
#(
    parameter int VALUE_FRAC = VALUE_FRAC_DEF
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [VALUE_W-1:0] scale,
    output logic signed [VALUE_W-1:0] inv,
    output logic                      zero
);

    // magnitude and rounded numerator
    logic [31:0] mag_c;
    logic [31:0] s0_mag_reg;
    logic        s0_neg_reg;
    logic        s0_zero_reg;
    logic [63:0] s0_num_reg;

    assign mag_c = scale[31] ? 32'(-scale) : 32'(scale);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_mag_reg  <= mag_c;
            s0_neg_reg  <= scale[31];
            s0_zero_reg <= (scale == '0);
            s0_num_reg  <= (64'd1 << (2 * VALUE_FRAC)) + 64'(mag_c >> 1);
        end
    end

    // divider stages
    logic [31:0] rem_reg  [33];
    logic [31:0] lo_reg   [33];
    logic [31:0] mag_reg  [33];
    logic        neg_reg  [33];
    logic        zero_reg [33];
    logic        ovf_reg  [33];

    // quotient would not fit 32 bits when the high word reaches the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= s0_num_reg[63:32];
            lo_reg[0]   <= s0_num_reg[31:0];
            mag_reg[0]  <= s0_mag_reg;
            neg_reg[0]  <= s0_neg_reg;
            zero_reg[0] <= s0_zero_reg;
            ovf_reg[0]  <= (s0_num_reg[63:32] >= s0_mag_reg);
        end
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_div
        logic [32:0] sh_c;
        logic [32:0] diff_c;
        logic        fits_c;

        always_comb
        begin
            sh_c   = {rem_reg[i], lo_reg[i][31]};
            diff_c = sh_c - {1'b0, mag_reg[i]};
            fits_c = (sh_c >= {1'b0, mag_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= fits_c ? diff_c[31:0] : sh_c[31:0];
                lo_reg[i+1]   <= {lo_reg[i][30:0], fits_c};
                mag_reg[i+1]  <= mag_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
            end
        end
    end

    // sign and saturation
    logic [31:0]        q_c;
    logic signed [31:0] res_c;

    always_comb
    begin
        q_c = lo_reg[32];
        if (zero_reg[32])
            res_c = 32'sh7fffffff;
        else if (neg_reg[32])
            res_c = (ovf_reg[32] || q_c > 32'h80000000) ? 32'sh80000000 : 32'(-q_c);
        else
            res_c = (ovf_reg[32] || q_c[31]) ? 32'sh7fffffff : $signed(q_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv  <= res_c;
            zero <= zero_reg[32];
        end
    end

endmodule

// ----- hdl/eyx_rotmat.sv -----
// ---------------------------------------------------------------------------
// eyx_rotmat
// Merges the three sine/cosine lanes into the Y-X-Z rotation matrix:
// pairwise Q30 products, then the triple products and sums.
// ---------------------------------------------------------------------------
module eyx_rotmat
    import eyx_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [TRIG_W-1:0]    s1,
    input  logic signed [TRIG_W-1:0]    c1,
    input  logic signed [TRIG_W-1:0]    s2,
    input  logic signed [TRIG_W-1:0]    c2,
    input  logic signed [TRIG_W-1:0]    s3,
    input  logic signed [TRIG_W-1:0]    c3,
    output logic [2:0][2:0][ROT_W-1:0]  rot
);

    // rounded Q30 product
    function automatic logic signed [ROT_W-1:0] mul30(input logic signed [ROT_W-1:0] a,
                                                      input logic signed [ROT_W-1:0] b);
        logic signed [2*ROT_W-1:0] p;
        p = a * b;
        p = p + (2*ROT_W)'(Q30_HALF);
        return ROT_W'(p >>> 30);
    endfunction

    logic signed [ROT_W-1:0] s1e, c1e, s2e, c2e, s3e, c3e;

    assign s1e = ROT_W'(s1);
    assign c1e = ROT_W'(c1);
    assign s2e = ROT_W'(s2);
    assign c2e = ROT_W'(c2);
    assign s3e = ROT_W'(s3);
    assign c3e = ROT_W'(c3);

    // pairwise products
    logic signed [ROT_W-1:0] c1c3_reg, s1s2_reg, c1s2_reg, c3s1_reg, c2s3_reg;
    logic signed [ROT_W-1:0] c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg, c1s3_reg;
    logic signed [ROT_W-1:0] s2_reg, s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1c3_reg <= mul30(c1e, c3e);
            s1s2_reg <= mul30(s1e, s2e);
            c1s2_reg <= mul30(c1e, s2e);
            c3s1_reg <= mul30(c3e, s1e);
            c2s3_reg <= mul30(c2e, s3e);
            c2c3_reg <= mul30(c2e, c3e);
            s1s3_reg <= mul30(s1e, s3e);
            c2s1_reg <= mul30(c2e, s1e);
            c1c2_reg <= mul30(c1e, c2e);
            c1s3_reg <= mul30(c1e, s3e);
            s2_reg   <= s2e;
            s3_reg   <= s3e;
        end
    end

    // triple products and sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot[0][0] <= c1c3_reg + mul30(s1s2_reg, s3_reg);
            rot[0][1] <= c2s3_reg;
            rot[0][2] <= mul30(c1s2_reg, s3_reg) - c3s1_reg;
            rot[1][0] <= mul30(c3s1_reg, s2_reg) - c1s3_reg;
            rot[1][1] <= c2c3_reg;
            rot[1][2] <= mul30(c1c3_reg, s2_reg) + s1s3_reg;
            rot[2][0] <= c2s1_reg;
            rot[2][1] <= -s2_reg;
            rot[2][2] <= c1c2_reg;
        end
    end

endmodule

// ----- hdl/eyx_emit.sv -----
// ---------------------------------------------------------------------------
// eyx_emit
// Column emitter: holds one item, steps through the seven columns, scales
// them in three multiplier lanes and drives the result register.
// ---------------------------------------------------------------------------
module eyx_emit
    import eyx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  item_t                      item,
    output logic                       take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       matrix_kind,
    output logic [1:0]                 column_index,
    output logic signed [VALUE_W-1:0]  elem_0,
    output logic signed [VALUE_W-1:0]  elem_1,
    output logic signed [VALUE_W-1:0]  elem_2,
    output logic                       zero_scale,
    output logic                       last_column
);

    localparam int PROD_W = VALUE_W + ROT_W;

    item_t             h_item_reg;
    logic              h_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              en_o;

    // result stage can move when empty or taken
    assign en_o = !out_valid || out_ready;
    assign take = en_o && (!h_valid_reg || cnt_reg == CNT_LAST);

    // hold register and column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                h_valid_reg <= item_valid;
                cnt_reg     <= '0;
            end
            else if (en_o && h_valid_reg)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            h_item_reg <= item;
    end

    // column select
    logic [1:0]                  row_c;
    logic signed [VALUE_W-1:0]   v_c;
    logic signed [ROT_W-1:0]     r_c [3];
    logic                        kind_c;

    always_comb
    begin
        kind_c = (cnt_reg < CNT_FIRST_NORMAL) ? KIND_MODEL : KIND_NORMAL;
        row_c  = (kind_c == KIND_NORMAL) ? 2'(cnt_reg - CNT_FIRST_NORMAL) : cnt_reg[1:0];
        if (cnt_reg == CNT_TRANSL)
            v_c = VALUE_W'(Q30_ONE);
        else if (kind_c == KIND_NORMAL)
            v_c = $signed(h_item_reg.inv[row_c]);
        else
            v_c = $signed(h_item_reg.scale[row_c]);
        for (int k = 0; k < 3; k++)
        begin
            if (cnt_reg == CNT_TRANSL)
                r_c[k] = ROT_W'($signed(h_item_reg.offset[k]));
            else
                r_c[k] = $signed(h_item_reg.rot[row_c][k]);
        end
    end

    // product stage
    logic                       p_valid_reg;
    logic signed [PROD_W-1:0]   p_prod_reg [3];
    logic                       p_kind_reg;
    logic [1:0]                 p_col_reg;
    logic                       p_zero_reg;
    logic                       p_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en_o)
            p_valid_reg <= h_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            for (int k = 0; k < 3; k++)
                p_prod_reg[k] <= PROD_W'(v_c) * PROD_W'(r_c[k]);
            p_kind_reg <= kind_c;
            p_col_reg  <= (kind_c == KIND_NORMAL) ? row_c : cnt_reg[1:0];
            p_zero_reg <= (kind_c == KIND_NORMAL) && h_item_reg.zero;
            p_last_reg <= (cnt_reg == CNT_LAST);
        end
    end

    // rounding and saturation into the result register
    logic signed [31:0] e_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            e_c[k] = sat32(35'((p_prod_reg[k] + PROD_W'(Q30_HALF)) >>> 30));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en_o)
            out_valid <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            elem_0       <= e_c[0];
            elem_1       <= e_c[1];
            elem_2       <= e_c[2];
            matrix_kind  <= p_kind_reg;
            column_index <= p_col_reg;
            zero_scale   <= p_zero_reg;
            last_column  <= p_last_reg;
        end
    end

    // counter stays within the seven columns
    assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg |-> cnt_reg <= CNT_LAST)
        else $error("column counter past last column");

    // last flag only on normal column two
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_column) |-> (matrix_kind == KIND_NORMAL && column_index == 2'd2))
        else $error("last column flag on wrong column");

    // model columns never carry the zero scale flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && matrix_kind == KIND_MODEL) |-> !zero_scale)
        else $error("zero scale flag on model column");

endmodule

// ----- hdl/euler_yxz_transform_matrix.sv -----
// ---------------------------------------------------------------------------
// euler_yxz_transform_matrix
// Y-X-Z Euler rotation, scale and translation to model and normal matrix
// columns.
// ---------------------------------------------------------------------------
// Each item gives seven result items: model columns 0..2, the translation
// column, then normal columns 0..2 (last_column on the final one). The
// seven columns leave through the single result register, and the next
// item is taken as the emitter reaches the last column; the front pipeline
// stalls while the emitter is busy. The path from input to the first
// column runs through the reciprocal lanes (one quotient bit per stage),
// two rotation-merge stages and the emitter's product and result stages.
// ---------------------------------------------------------------------------
module euler_yxz_transform_matrix
    import eyx_pkg::*;
#(
    parameter int ANGLE_FRAC   = ANGLE_FRAC_DEF,
    parameter int VALUE_FRAC   = VALUE_FRAC_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [ANGLE_W-1:0] angle_x,
    input  logic signed [ANGLE_W-1:0] angle_y,
    input  logic signed [ANGLE_W-1:0] angle_z,
    input  logic signed [VALUE_W-1:0] scale_x,
    input  logic signed [VALUE_W-1:0] scale_y,
    input  logic signed [VALUE_W-1:0] scale_z,
    input  logic signed [VALUE_W-1:0] offset_x,
    input  logic signed [VALUE_W-1:0] offset_y,
    input  logic signed [VALUE_W-1:0] offset_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      matrix_kind,
    output logic [1:0]                column_index,
    output logic signed [VALUE_W-1:0] elem_0,
    output logic signed [VALUE_W-1:0] elem_1,
    output logic signed [VALUE_W-1:0] elem_2,
    output logic                      zero_scale,
    output logic                      last_column
);

    localparam int SC_LAT    = CORDIC_STEPS + 4;
    localparam int SC_PAD    = RCP_LAT - SC_LAT;
    localparam int ROT_LAT   = 2;
    localparam int FRONT_LAT = RCP_LAT + ROT_LAT;

    logic                 en;
    logic                 take;
    logic [FRONT_LAT-1:0] vld_reg;

    // whole front advances unless its last item waits on the emitter
    assign en       = !vld_reg[FRONT_LAT-1] || take;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
    end

    // sine/cosine lanes: y -> 1, x -> 2, z -> 3
    logic signed [TRIG_W-1:0] s1, c1, s2, c2, s3, c3;

    eyx_sincos #(.ANGLE_FRAC(ANGLE_FRAC), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
        .clk(clk), .en(en), .angle(angle_y), .sin_val(s1), .cos_val(c1)
    );
    eyx_sincos #(.ANGLE_FRAC(ANGLE_FRAC), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
        .clk(clk), .en(en), .angle(angle_x), .sin_val(s2), .cos_val(c2)
    );
    eyx_sincos #(.ANGLE_FRAC(ANGLE_FRAC), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
        .clk(clk), .en(en), .angle(angle_z), .sin_val(s3), .cos_val(c3)
    );

    // reciprocal lanes
    logic signed [VALUE_W-1:0] inv_x, inv_y, inv_z;
    logic                      zero_x, zero_y, zero_z;

    eyx_recip #(.VALUE_FRAC(VALUE_FRAC)) u_rcp_x (
        .clk(clk), .en(en), .scale(scale_x), .inv(inv_x), .zero(zero_x)
    );
    eyx_recip #(.VALUE_FRAC(VALUE_FRAC)) u_rcp_y (
        .clk(clk), .en(en), .scale(scale_y), .inv(inv_y), .zero(zero_y)
    );
    eyx_recip #(.VALUE_FRAC(VALUE_FRAC)) u_rcp_z (
        .clk(clk), .en(en), .scale(scale_z), .inv(inv_z), .zero(zero_z)
    );

    // align sine/cosine with the reciprocal lanes
    logic [5:0][TRIG_W-1:0] trig_pad_reg [SC_PAD];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_pad_reg[0] <= {s1, c1, s2, c2, s3, c3};
            for (int k = 1; k < SC_PAD; k++)
                trig_pad_reg[k] <= trig_pad_reg[k-1];
        end
    end

    // rotation merge
    logic [2:0][2:0][ROT_W-1:0] rot;
    logic [5:0][TRIG_W-1:0]     trig_al;

    assign trig_al = trig_pad_reg[SC_PAD-1];

    eyx_rotmat u_rot (
        .clk(clk), .en(en),
        .s1($signed(trig_al[5])), .c1($signed(trig_al[4])),
        .s2($signed(trig_al[3])), .c2($signed(trig_al[2])),
        .s3($signed(trig_al[1])), .c3($signed(trig_al[0])),
        .rot(rot)
    );

    // reciprocals and flag wait for the merge
    logic [2:0][VALUE_W-1:0] inv_dly_reg  [ROT_LAT];
    logic                    zero_dly_reg [ROT_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_dly_reg[0]  <= {inv_z, inv_y, inv_x};
            zero_dly_reg[0] <= zero_x || zero_y || zero_z;
            for (int k = 1; k < ROT_LAT; k++)
            begin
                inv_dly_reg[k]  <= inv_dly_reg[k-1];
                zero_dly_reg[k] <= zero_dly_reg[k-1];
            end
        end
    end

    // scales and offsets ride along the front
    logic [5:0][VALUE_W-1:0] so_dly_reg [FRONT_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            so_dly_reg[0] <= {offset_z, offset_y, offset_x, scale_z, scale_y, scale_x};
            for (int k = 1; k < FRONT_LAT; k++)
                so_dly_reg[k] <= so_dly_reg[k-1];
        end
    end

    // item for the emitter
    item_t item_c;

    always_comb
    begin
        item_c.rot    = rot;
        item_c.scale  = so_dly_reg[FRONT_LAT-1][2:0];
        item_c.offset = so_dly_reg[FRONT_LAT-1][5:3];
        item_c.inv    = inv_dly_reg[ROT_LAT-1];
        item_c.zero   = zero_dly_reg[ROT_LAT-1];
    end

    eyx_emit u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(vld_reg[FRONT_LAT-1]),
        .item(item_c),
        .take(take),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .matrix_kind(matrix_kind),
        .column_index(column_index),
        .elem_0(elem_0),
        .elem_1(elem_1),
        .elem_2(elem_2),
        .zero_scale(zero_scale),
        .last_column(last_column)
    );

endmodule
